### hdl/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg - date add days shared definitions
// Month length table, leap test on the year modulo 400, default widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dad_pkg;

	localparam int COUNT_BITS_DEF = 20;
	localparam int YEAR_BITS_DEF  = 15;

	// 400 Gregorian years hold exactly this many days
	localparam int CYCLE_DAYS  = 146097;
	localparam int CYCLE_YEARS = 400;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [8:0] YMOD_LAST = 9'd399;

	localparam logic [4:0] MONTH_LEN [0:12] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// leap test from year mod 400 (year mod 4 equals its low two bits)
	function automatic logic is_leap(input logic [8:0] ymod);
		logic cent;
		cent = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
		return (ymod == 9'd0) || ((ymod[1:0] == 2'd0) && !cent);
	endfunction

	// days in month; zero for a month code that is not a month
	function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
		logic [4:0] n;
		n = (mon > MONTH_DEC) ? 5'd0 : MONTH_LEN[mon];
		if (mon == MONTH_FEB && leap) begin
			n = n + 5'd1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### hdl/date_add_days.sv
// ----------------------------------------------------------------------------
// date_add_days - Gregorian date plus a count of days
// Iterative walk over month boundaries with one shared subtract/compare unit.
// ----------------------------------------------------------------------------
// Steps: load, year mod 400 by restoring subtraction, date check,
//   400-year reduction of the count (only if COUNT_BITS >= 18),
//   then a walk over the months crossed; a bad start date skips to done.
// Requests: one at a time; s_tready is high only while idle, and
//   the result holds in the output register until taken.
// Reset: arst_n asynchronously returns the sequencer to idle, no result valid.
`default_nettype none

module date_add_days #(
	parameter int COUNT_BITS = dad_pkg::COUNT_BITS_DEF,
	parameter int YEAR_BITS  = dad_pkg::YEAR_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// request: start_day, start_month, start_year, day_count (lowest bit up)
	input  wire logic [((9 + YEAR_BITS + COUNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// result: out_day, out_month, out_year (lowest bit up)
	output logic [31:0] m_tdata,
	// result flag: bad_date
	output logic [0:0]  m_tuser,
	output logic        m_tvalid,
	input  wire logic   m_tready
);

	// shared unit width: wide enough for the year, the count and 146097
	localparam int WMAX = (COUNT_BITS > YEAR_BITS) ? COUNT_BITS : YEAR_BITS;
	localparam int WU   = (WMAX > 18) ? WMAX : 18;

	// restoring-division start shifts: 400 < 2^9, 146097 < 2^18
	localparam int  KY      = YEAR_BITS - 9;
	localparam bit  HAS_DIV = (COUNT_BITS >= 18);
	localparam int  KC      = HAS_DIV ? COUNT_BITS - 18 : 0;
	localparam int  KMAX    = (KY > KC) ? KY : KC;
	localparam int  KW      = $clog2(KMAX + 1);

	localparam int  F_MON  = 5;
	localparam int  F_YEAR = 9;
	localparam int  F_CNT  = 9 + YEAR_BITS;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MOD  = 6'b000010,
		ST_CHK  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_WALK = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;

	logic [4:0]            day_q;
	logic [3:0]            mon_q;
	logic [15:0]           year_q;   // low bits only; leap test runs on year mod 400
	logic [8:0]            ymod_q;   // year mod 400
	logic [YEAR_BITS-1:0]  rem_q;    // year being reduced mod 400
	logic [COUNT_BITS-1:0] cnt_q;
	logic [KW-1:0]         k_q;
	logic                  bad_q;

	// shared subtract/compare unit
	logic [WU:0] sub_a, sub_b, sub_d;
	logic        sub_ge;

	logic        leap_sel;
	logic [4:0]  mlen;
	logic [4:0]  left;
	logic        start_bad;
	logic [15:0] year_step;

	assign leap_sel = dad_pkg::is_leap((state_q == ST_CHK) ? rem_q[8:0] : ymod_q);
	assign mlen     = dad_pkg::month_days(mon_q, leap_sel);
	assign left     = mlen - day_q;
	assign start_bad = (mon_q == 4'd0) || (mon_q > dad_pkg::MONTH_DEC)
		|| (day_q == 5'd0) || (day_q > mlen);
	assign year_step = 16'(32'(dad_pkg::CYCLE_YEARS) << k_q);

	always_comb begin
		sub_a = '0;
		sub_b = '0;
		unique case (state_q)
			ST_MOD: begin
				sub_a = (WU + 1)'(rem_q);
				sub_b = (WU + 1)'(dad_pkg::CYCLE_YEARS) << k_q;
			end
			ST_DIV: begin
				sub_a = (WU + 1)'(cnt_q);
				sub_b = (WU + 1)'(dad_pkg::CYCLE_DAYS) << k_q;
			end
			ST_WALK: begin
				// past month end when count >= days left + 1
				sub_a = (WU + 1)'(cnt_q);
				sub_b = (WU + 1)'({1'b0, left} + 6'd1);
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign sub_d  = sub_a - sub_b;
	assign sub_ge = !sub_d[WU];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MOD;
						k_q     <= KW'(KY);
					end
				end
				ST_MOD: begin
					if (k_q == '0) begin
						state_q <= ST_CHK;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_CHK: begin
					if (start_bad) begin
						state_q <= ST_DONE;
					end else if (HAS_DIV) begin
						state_q <= ST_DIV;
						k_q     <= KW'(KC);
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_DIV: begin
					if (k_q == '0) begin
						state_q <= ST_WALK;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_WALK: begin
					if (!sub_ge) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				day_q  <= s_tdata[4:0];
				mon_q  <= s_tdata[F_MON +: 4];
				year_q <= 16'(s_tdata[F_YEAR +: YEAR_BITS]);
				rem_q  <= s_tdata[F_YEAR +: YEAR_BITS];
				cnt_q  <= s_tdata[F_CNT +: COUNT_BITS];
			end
			ST_MOD: begin
				if (sub_ge) begin
					rem_q <= sub_d[YEAR_BITS-1:0];
				end
			end
			ST_CHK: begin
				bad_q  <= start_bad;
				ymod_q <= rem_q[8:0];
			end
			ST_DIV: begin
				// whole 400-year cycles: year mod 400 is unchanged
				if (sub_ge) begin
					cnt_q  <= sub_d[COUNT_BITS-1:0];
					year_q <= year_q + year_step;
				end
			end
			ST_WALK: begin
				if (sub_ge) begin
					cnt_q <= sub_d[COUNT_BITS-1:0];
					day_q <= 5'd1;
					if (mon_q == dad_pkg::MONTH_DEC) begin
						mon_q  <= dad_pkg::MONTH_JAN;
						year_q <= year_q + 16'd1;
						ymod_q <= (ymod_q == dad_pkg::YMOD_LAST) ? 9'd0 : ymod_q + 9'd1;
					end else begin
						mon_q <= mon_q + 4'd1;
					end
				end else begin
					// count no greater than the days left in the month: lands inside it
					day_q <= day_q + cnt_q[4:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_DONE);
	assign m_tdata  = {7'd0, year_q, mon_q, day_q};
	assign m_tuser  = bad_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("request and result side open together");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("new request taken while one is in work");

	a_ymod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (ymod_q <= dad_pkg::YMOD_LAST))
		else $error("year mod 400 out of range");

	a_good_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[4:0] != 5'd0 && m_tdata[8:5] != 4'd0
			&& m_tdata[8:5] <= dad_pkg::MONTH_DEC))
		else $error("valid start date gave a result outside the calendar");

endmodule

`default_nettype wire
